// ===== rtl/rvcq_pkg.sv =====
// rvcq_pkg: shared widths, mode codes and the status struct of the range
// value count query block. Depends on nothing.
`default_nettype none

package rvcq_pkg;

   // fixed field widths of the request and response items
   localparam int ITEM_VALUE_W = 16;
   localparam int BOUND_W      = 11;
   localparam int COUNT_W      = 11;

   // defaults for the top level parameters
   localparam int DEFAULT_DEPTH      = 1024;
   localparam int DEFAULT_VALUE_BITS = 16;

   // request mode codes
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // status handed from the scan sequencer to the top level
   typedef struct packed {
      logic busy;
      logic rsp_valid;
   } scan_status_type;

endpackage

`default_nettype wire

// ===== rtl/rvcq_mem.sv =====
// rvcq_mem: value store, one write port and one read port with registered
// read data. Depends on nothing.
`default_nettype none

module rvcq_mem #(
   parameter int DEPTH      = 1024,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [VALUE_BITS-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [VALUE_BITS-1:0]    rd_data
);

   logic [VALUE_BITS-1:0] store_ff [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/rvcq_seq.sv =====
// rvcq_seq: scan sequencer. Walks the query range one position a cycle,
// compares each stored value and counts the hits. Depends on rvcq_pkg.
`default_nettype none

module rvcq_seq #(
   parameter int DEPTH      = 1024,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic [rvcq_pkg::BOUND_W-1:0]            left_bound,
   input  wire logic [rvcq_pkg::BOUND_W-1:0]            right_bound,
   input  wire logic [$clog2(DEPTH+1)-1:0]              loaded,
   input  wire logic [VALUE_BITS-1:0]                   key,
   output logic                                         rd_en,
   output logic      [$clog2(DEPTH)-1:0]                rd_addr,
   input  wire logic [VALUE_BITS-1:0]                   rd_data,
   output rvcq_pkg::scan_status_type                    status,
   output logic      [rvcq_pkg::COUNT_W-1:0]            match_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > rvcq_pkg::BOUND_W) ? CW : rvcq_pkg::BOUND_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [PW-1:0]                  idx_ff, idx_in;
   logic [PW-1:0]                  last_ff, last_in;
   logic [VALUE_BITS-1:0]          key_ff, key_in;
   logic [rvcq_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           rdv_ff, rdv_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rvcq_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [rvcq_pkg::BOUND_W-1:0]   lo_adj;
   logic [PW-1:0]                  first_pos;
   logic [PW-1:0]                  hi_ext;
   logic [PW-1:0]                  loaded_ext;
   logic [PW-1:0]                  lim_pos;
   logic                           range_empty;
   logic                           hit;

   // clamp the range: no position zero, nothing past the load
   always_comb begin
      lo_adj      = (left_bound == '0) ? rvcq_pkg::BOUND_W'(1) : left_bound;
      first_pos   = PW'(lo_adj - rvcq_pkg::BOUND_W'(1));
      hi_ext      = PW'(right_bound);
      loaded_ext  = PW'(loaded);
      lim_pos     = (hi_ext > loaded_ext) ? loaded_ext : hi_ext;
      range_empty = (first_pos >= lim_pos);
   end

   // the shared compare unit
   assign hit = rdv_ff && (rd_data == key_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rdv_in       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = key;
               if (range_empty) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
               end else begin
                  idx_in   = first_pos;
                  last_in  = lim_pos - PW'(1);
                  count_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            rdv_in = 1'b1;
            idx_in = idx_ff + PW'(1);
            if (hit) begin
               count_in = count_ff + rvcq_pkg::COUNT_W'(1);
            end
            if (idx_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read comes back here
            rsp_valid_in = 1'b1;
            rsp_count_in = count_ff + {{(rvcq_pkg::COUNT_W-1){1'b0}}, hit};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      key_ff       <= key_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rd_addr          = idx_ff[AW-1:0];
   assign status.busy      = (state_ff != ST_IDLE);
   assign status.rsp_valid = rsp_valid_ff;
   assign match_count      = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/range_value_count_query.sv =====
// range_value_count_query: top level. Holds the load count, drives the value
// store and the scan sequencer. Depends on rvcq_pkg, rvcq_mem and rvcq_seq.
//
//   channel   ports                                          handshake
//   request   req_mode req_item_value req_left_bound         start && !busy
//             req_right_bound
//   response  rsp_match_count                                rsp_valid strobe
//
// An append item writes the next free position; an append into a full store
// is dropped. A query item scans the clamped range one position a cycle
// through the single read port of the value store: busy over the scan and
// over the drain state in which the last read returns, then the strobe in
// the cycle after; an empty range answers on the next cycle without raising
// busy. Busy stays high over the scan. Synchronous reset empties the store by
// clearing the load count only; the receiver cannot stall, so each result is
// shown for one cycle.
`default_nettype none

module range_value_count_query #(
   parameter int DEPTH      = rvcq_pkg::DEFAULT_DEPTH,
   parameter int VALUE_BITS = rvcq_pkg::DEFAULT_VALUE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_mode,
   input  wire logic [rvcq_pkg::ITEM_VALUE_W-1:0]   req_item_value,
   input  wire logic [rvcq_pkg::BOUND_W-1:0]        req_left_bound,
   input  wire logic [rvcq_pkg::BOUND_W-1:0]        req_right_bound,
   output logic                                     rsp_valid,
   output logic      [rvcq_pkg::COUNT_W-1:0]        rsp_match_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]             loaded_ff, loaded_in;
   logic [VALUE_BITS-1:0]     key;
   logic                      accept;
   logic                      store_full;
   logic                      do_append;
   logic                      do_query;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [VALUE_BITS-1:0]     rd_data;
   rvcq_pkg::scan_status_type scan_status;

   // use the low VALUE_BITS of the item value, zero-extend if wider
   generate
      if (VALUE_BITS <= rvcq_pkg::ITEM_VALUE_W) begin : g_key_trim
         assign key = req_item_value[VALUE_BITS-1:0];
      end else begin : g_key_ext
         assign key = {{(VALUE_BITS-rvcq_pkg::ITEM_VALUE_W){1'b0}}, req_item_value};
      end
   endgenerate

   assign busy       = scan_status.busy;
   assign accept     = start && !busy;
   assign store_full = (loaded_ff == CW'(DEPTH));
   assign do_append  = accept && (req_mode == rvcq_pkg::MODE_APPEND) && !store_full;
   assign do_query   = accept && (req_mode == rvcq_pkg::MODE_QUERY);

   // advance the load count on every append that fits; drop the rest
   always_comb begin
      loaded_in = loaded_ff;
      if (do_append) begin
         loaded_in = loaded_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else begin
         loaded_ff <= loaded_in;
      end
   end

   rvcq_mem #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (do_append),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data (key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rvcq_seq #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (do_query),
      .left_bound  (req_left_bound),
      .right_bound (req_right_bound),
      .loaded      (loaded_ff),
      .key         (key),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .status      (scan_status),
      .match_count (rsp_match_count)
   );

   assign rsp_valid = scan_status.rsp_valid;

   // results only show once the scan has let go of busy
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while scan still busy");

   // an append never gives a result
   a_append_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == rvcq_pkg::MODE_APPEND)) |=> !rsp_valid)
      else $error("response after an append item");

   // a count cannot exceed the number of loaded positions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((CW + rvcq_pkg::COUNT_W)'(rsp_match_count)
                     <= (CW + rvcq_pkg::COUNT_W)'(loaded_ff)))
      else $error("match count above load count");

   // the load count never runs past the store
   a_load_limit: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(loaded_ff) <= (CW + 1)'(DEPTH))
      else $error("load count past depth");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for range_value_count_query. Holds a small
// count scoreboard with its own copy of the value array and drives the block.
// Depends on rvcq_pkg and the range_value_count_query RTL.

module tb_top;

   localparam int STORE_DEPTH = rvcq_pkg::DEFAULT_DEPTH;
   localparam int BOUND_MAX   = (1 << rvcq_pkg::BOUND_W) - 1;

   // eight values that recur often, so that queries actually find matches
   localparam logic [rvcq_pkg::ITEM_VALUE_W-1:0] VALUE_POOL [8] = '{
      16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1234, 16'h00FF, 16'hFF00, 16'h5555
   };

   // Count scoreboard: mirrors the loaded array and the load count, works out
   // the expected count for each accepted query and checks results in order.
   class count_scoreboard;
      logic [rvcq_pkg::ITEM_VALUE_W-1:0] store [STORE_DEPTH];
      int unsigned                       fill;
      logic [rvcq_pkg::COUNT_W-1:0]      pending_counts [$];
      int unsigned                       errors;

      // Clamp the range to [1, fill]; an empty range simply counts nothing.
      function logic [rvcq_pkg::COUNT_W-1:0] count_in_range(
            logic [rvcq_pkg::ITEM_VALUE_W-1:0] value,
            logic [rvcq_pkg::BOUND_W-1:0] lo,
            logic [rvcq_pkg::BOUND_W-1:0] hi);
         int unsigned first;
         int unsigned last;
         int unsigned n;
         first = (lo == 0) ? 1 : lo;
         last  = (hi > fill) ? fill : hi;
         n     = 0;
         for (int unsigned p = first; p <= last; p++) begin
            if (store[p-1] == value) n++;
         end
         return rvcq_pkg::COUNT_W'(n);
      endfunction

      // Note an accepted item: append to the mirror, or queue the expected count.
      function void note_item(logic mode, logic [rvcq_pkg::ITEM_VALUE_W-1:0] value,
                              logic [rvcq_pkg::BOUND_W-1:0] lo,
                              logic [rvcq_pkg::BOUND_W-1:0] hi);
         if (mode == rvcq_pkg::MODE_APPEND) begin
            if (fill < STORE_DEPTH) begin
               store[fill] = value;
               fill++;
            end
         end else begin
            pending_counts = {pending_counts, count_in_range(value, lo, hi)};
         end
      endfunction

      // Check one result against the oldest expected count.
      function void check_count(logic [rvcq_pkg::COUNT_W-1:0] got);
         logic [rvcq_pkg::COUNT_W-1:0] want;
         if (pending_counts.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result, match_count %0d", $realtime, got);
         end else begin
            want = pending_counts.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: match_count mismatch, expected %0d, got %0d",
                           $realtime, want, got);
            end
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_mode;
   logic [rvcq_pkg::ITEM_VALUE_W-1:0] req_item_value;
   logic [rvcq_pkg::BOUND_W-1:0]      req_left_bound;
   logic [rvcq_pkg::BOUND_W-1:0]      req_right_bound;
   logic                              rsp_valid;
   logic [rvcq_pkg::COUNT_W-1:0]      rsp_match_count;

   count_scoreboard sb = new;

   // percentage of cycles in which the sender holds off, and the share of appends
   int idle_pct;
   int append_pct;

   range_value_count_query u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_item_value  (req_item_value),
      .req_left_bound  (req_left_bound),
      .req_right_bound (req_right_bound),
      .rsp_valid       (rsp_valid),
      .rsp_match_count (rsp_match_count)
   );

   always #2 clock = ~clock;

   // Sample results at the rising edge; the strobe lasts exactly one cycle and
   // cannot be held off, so every strobed cycle is one result.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_count(rsp_match_count);
   end

   // Present one item from a falling edge and hold it until the block takes it.
   // Start is only lowered during idle cycles, so back-to-back items keep it high
   // without a second assignment in the same step.
   task automatic send_item(input logic mode,
                            input logic [rvcq_pkg::ITEM_VALUE_W-1:0] value,
                            input logic [rvcq_pkg::BOUND_W-1:0] lo,
                            input logic [rvcq_pkg::BOUND_W-1:0] hi);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_item_value  <= value;
      req_left_bound  <= lo;
      req_right_bound <= hi;
      do @(posedge clock); while (busy);
      sb.note_item(mode, value, lo, hi);
      @(negedge clock);
   endtask

   // Draw a value: mostly from the pool or from what is already loaded, so that
   // counts are non-trivial; now and then any 16-bit value.
   function automatic logic [rvcq_pkg::ITEM_VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return VALUE_POOL[$urandom_range(0, 7)];
      if (r < 8 && sb.fill > 0) return sb.store[$urandom_range(0, sb.fill - 1)];
      return rvcq_pkg::ITEM_VALUE_W'($urandom);
   endfunction

   // One random item. Queries are mostly narrow windows around the loaded part
   // (a scan costs a cycle per position), with some wide ranges, empty ranges
   // and fully random bounds, which also reach past the load and past the depth.
   task automatic random_item();
      logic                              mode;
      logic [rvcq_pkg::ITEM_VALUE_W-1:0] value;
      int                                lo;
      int                                hi;
      int                                r;
      mode  = ($urandom_range(0, 99) < append_pct) ? rvcq_pkg::MODE_APPEND
                                                   : rvcq_pkg::MODE_QUERY;
      value = pick_value();
      r     = $urandom_range(0, 19);
      if (r < 14) begin
         lo = $urandom_range(0, sb.fill + 2);
         hi = lo + $urandom_range(0, 48);
      end else if (r < 16) begin
         lo = $urandom_range(0, 3);
         hi = $urandom_range(sb.fill, BOUND_MAX);
      end else if (r == 16) begin
         hi = $urandom_range(0, 1000);
         lo = $urandom_range(hi + 1, BOUND_MAX);
      end else begin
         lo = $urandom_range(0, BOUND_MAX);
         hi = $urandom_range(0, BOUND_MAX);
      end
      if (hi > BOUND_MAX) hi = BOUND_MAX;
      send_item(mode, value, rvcq_pkg::BOUND_W'(lo), rvcq_pkg::BOUND_W'(hi));
   endtask

   // Stop a hung run well beyond the slowest correct one.
   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int phase_idle [4];
      phase_idle = '{0, 67, 0, 27};
      idle_pct        = 0;
      append_pct      = 45;
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = rvcq_pkg::MODE_APPEND;
      req_item_value  = '0;
      req_left_bound  = '0;
      req_right_bound = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed: query the empty array, load the extreme values, then hit the
      // empty range, a zero left bound, bounds past the load and past the depth.
      send_item(rvcq_pkg::MODE_QUERY,  16'h0000, 11'd1,    11'd1024);
      send_item(rvcq_pkg::MODE_APPEND, 16'h0000, 11'h7FF,  11'h000);
      send_item(rvcq_pkg::MODE_APPEND, 16'hFFFF, 11'h000,  11'h7FF);
      send_item(rvcq_pkg::MODE_APPEND, 16'h5A5A, 11'h555,  11'h2AA);
      send_item(rvcq_pkg::MODE_APPEND, 16'hA5A5, 11'h2AA,  11'h555);
      send_item(rvcq_pkg::MODE_APPEND, 16'h0000, 11'd0,    11'd0);
      send_item(rvcq_pkg::MODE_APPEND, 16'hFFFF, 11'd0,    11'd0);
      send_item(rvcq_pkg::MODE_QUERY,  16'h0000, 11'd1,    11'd6);
      send_item(rvcq_pkg::MODE_QUERY,  16'hFFFF, 11'd0,    11'h7FF);
      send_item(rvcq_pkg::MODE_QUERY,  16'h0000, 11'd5,    11'd2);
      send_item(rvcq_pkg::MODE_QUERY,  16'hA5A5, 11'd4,    11'd4);
      send_item(rvcq_pkg::MODE_QUERY,  16'h5A5A, 11'd3,    11'd3);
      send_item(rvcq_pkg::MODE_QUERY,  16'hA5A5, 11'h7FF,  11'h7FF);
      send_item(rvcq_pkg::MODE_QUERY,  16'h0000, 11'd1024, 11'd1024);
      send_item(rvcq_pkg::MODE_QUERY,  16'h0000, 11'd0,    11'd0);
      send_item(rvcq_pkg::MODE_QUERY,  16'hFFFF, 11'd7,    11'd100);
      send_item(rvcq_pkg::MODE_QUERY,  16'h1234, 11'd1,    11'd6);
      send_item(rvcq_pkg::MODE_QUERY,  16'hFFFF, 11'd2,    11'd6);

      // Random phases: no idling, heavy sender gaps, none again, light gaps.
      foreach (phase_idle[i]) begin
         idle_pct = phase_idle[i];
         repeat (140) random_item();
      end
      start <= 1'b0;

      // Drain: wait for every expected count, then allow a full scan for strays.
      while (sb.pending_counts.size() != 0) @(negedge clock);
      repeat (STORE_DEPTH + 64) @(negedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
